>>> hw/rtl/halfwidth_katakana_to_utf8_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the half-width katakana to UTF-8 converter
// ----------------------------------------------------------------------------
`ifndef HALFWIDTH_KATAKANA_TO_UTF8_DEFINES_SVH
`define HALFWIDTH_KATAKANA_TO_UTF8_DEFINES_SVH

// Same-cycle implication, masked while reset is held.
`define HWK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define HWK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hwk_pkg.sv
// ----------------------------------------------------------------------------
// hwk_pkg
// Shared types, code tables and constants of the katakana to UTF-8 converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hwk_pkg;

    localparam int HWK_QUEUE_DEPTH = 4;

    localparam logic [7:0] KANA_FIRST  = 8'hA1;
    localparam logic [7:0] KANA_LAST   = 8'hDD;
    localparam logic [7:0] VOICED_MARK = 8'hDE;
    localparam logic [7:0] SEMI_MARK   = 8'hDF;
    localparam logic [7:0] VOICE_A_LO  = 8'hB6;
    localparam logic [7:0] VOICE_A_HI  = 8'hC4;
    localparam logic [7:0] VOICE_B_LO  = 8'hCA;
    localparam logic [7:0] VOICE_B_HI  = 8'hCE;
    localparam logic [7:0] ASCII_LO    = 8'h20;
    localparam logic [7:0] ASCII_HI    = 8'h7F;

    // Kind of the second slot of a record
    typedef enum logic [1:0] {
        B_NONE = 2'd0,
        B_BYTE = 2'd1,
        B_CODE = 2'd2
    } t_bkind;

    // One item's worth of output: an optional code, an optional byte or code,
    // an optional closing zero byte, emitted in that order.
    typedef struct packed {
        logic        a_v;
        logic [23:0] a_code;
        t_bkind      b_kind;
        logic [23:0] b_val;
        logic        z_v;
    } t_rec;

    function automatic logic [23:0] kana_code(input logic [7:0] b);
        logic [23:0] c;
        unique case (b)
            8'hA1: c = 24'hE38082;  8'hA2: c = 24'hE3808C;  8'hA3: c = 24'hE3808D;
            8'hA4: c = 24'hE38081;  8'hA5: c = 24'hE383BB;  8'hA6: c = 24'hE383B2;
            8'hA7: c = 24'hE382A1;  8'hA8: c = 24'hE382A3;  8'hA9: c = 24'hE382A5;
            8'hAA: c = 24'hE382A7;  8'hAB: c = 24'hE382A9;  8'hAC: c = 24'hE383A3;
            8'hAD: c = 24'hE383A5;  8'hAE: c = 24'hE383A7;  8'hAF: c = 24'hE38383;
            8'hB0: c = 24'hE383BC;  8'hB1: c = 24'hE382A2;  8'hB2: c = 24'hE382A4;
            8'hB3: c = 24'hE382A6;  8'hB4: c = 24'hE382A8;  8'hB5: c = 24'hE382AA;
            8'hB6: c = 24'hE382AB;  8'hB7: c = 24'hE382AD;  8'hB8: c = 24'hE382AF;
            8'hB9: c = 24'hE382B1;  8'hBA: c = 24'hE382B3;  8'hBB: c = 24'hE382B5;
            8'hBC: c = 24'hE382B7;  8'hBD: c = 24'hE382B9;  8'hBE: c = 24'hE382BB;
            8'hBF: c = 24'hE382BD;  8'hC0: c = 24'hE382BF;  8'hC1: c = 24'hE38381;
            8'hC2: c = 24'hE38384;  8'hC3: c = 24'hE38386;  8'hC4: c = 24'hE38388;
            8'hC5: c = 24'hE3838A;  8'hC6: c = 24'hE3838B;  8'hC7: c = 24'hE3838C;
            8'hC8: c = 24'hE3838D;  8'hC9: c = 24'hE3838E;  8'hCA: c = 24'hE3838F;
            8'hCB: c = 24'hE38392;  8'hCC: c = 24'hE38395;  8'hCD: c = 24'hE38398;
            8'hCE: c = 24'hE3839B;  8'hCF: c = 24'hE3839E;  8'hD0: c = 24'hE3839F;
            8'hD1: c = 24'hE383A0;  8'hD2: c = 24'hE383A1;  8'hD3: c = 24'hE383A2;
            8'hD4: c = 24'hE383A4;  8'hD5: c = 24'hE383A6;  8'hD6: c = 24'hE383A8;
            8'hD7: c = 24'hE383A9;  8'hD8: c = 24'hE383AA;  8'hD9: c = 24'hE383AB;
            8'hDA: c = 24'hE383AC;  8'hDB: c = 24'hE383AD;  8'hDC: c = 24'hE383AF;
            8'hDD: c = 24'hE383B3;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    // Voiced form of the first voiceable group
    function automatic logic [23:0] voiced_a_code(input logic [7:0] k);
        logic [23:0] c;
        unique case (k)
            8'hB6: c = 24'hE382AC;  8'hB7: c = 24'hE382AE;  8'hB8: c = 24'hE382B0;
            8'hB9: c = 24'hE382B2;  8'hBA: c = 24'hE382B4;  8'hBB: c = 24'hE382B6;
            8'hBC: c = 24'hE382B8;  8'hBD: c = 24'hE382BA;  8'hBE: c = 24'hE382BC;
            8'hBF: c = 24'hE382BE;  8'hC0: c = 24'hE38380;  8'hC1: c = 24'hE38382;
            8'hC2: c = 24'hE38385;  8'hC3: c = 24'hE38387;  8'hC4: c = 24'hE38389;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    // Voiced form of the group that also takes the semi-voiced mark
    function automatic logic [23:0] voiced_b_code(input logic [7:0] k);
        logic [23:0] c;
        unique case (k)
            8'hCA: c = 24'hE38390;  8'hCB: c = 24'hE38393;  8'hCC: c = 24'hE38396;
            8'hCD: c = 24'hE38399;  8'hCE: c = 24'hE3839C;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    function automatic logic [23:0] semi_b_code(input logic [7:0] k);
        logic [23:0] c;
        unique case (k)
            8'hCA: c = 24'hE38391;  8'hCB: c = 24'hE38394;  8'hCC: c = 24'hE38397;
            8'hCD: c = 24'hE3839A;  8'hCE: c = 24'hE3839D;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/hwk_front.sv
// ----------------------------------------------------------------------------
// hwk_front
// Accepts source bytes, tracks the pending kana and the closed string, and
// turns each byte into at most one output record for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "halfwidth_katakana_to_utf8_defines.svh"

module hwk_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [7:0]     i_in_byte,
    input  logic           i_end_of_input,
    input  logic           i_q_full,
    output logic           o_full,
    output logic           o_wr,
    output hwk_pkg::t_rec  o_rec
);
    import hwk_pkg::*;

    logic       r_pend_valid, n_pend_valid;
    logic [7:0] r_pend_kana,  n_pend_kana;
    logic       r_closed,     n_closed;

    logic       accept;
    logic       consumed;
    logic [23:0] comb_code;
    logic       pend_a, pend_b, new_a, new_b;
    t_rec       rec;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    assign pend_a = (r_pend_kana >= VOICE_A_LO) && (r_pend_kana <= VOICE_A_HI);
    assign pend_b = (r_pend_kana >= VOICE_B_LO) && (r_pend_kana <= VOICE_B_HI);
    assign new_a  = (i_in_byte >= VOICE_A_LO) && (i_in_byte <= VOICE_A_HI);
    assign new_b  = (i_in_byte >= VOICE_B_LO) && (i_in_byte <= VOICE_B_HI);

    always_comb begin
        consumed  = 1'b0;
        comb_code = 24'h000000;
        if (r_pend_valid) begin
            priority if (i_in_byte == VOICED_MARK && pend_a) begin
                consumed  = 1'b1;
                comb_code = voiced_a_code(r_pend_kana);
            end else if (i_in_byte == VOICED_MARK && pend_b) begin
                consumed  = 1'b1;
                comb_code = voiced_b_code(r_pend_kana);
            end else if (i_in_byte == SEMI_MARK && pend_b) begin
                consumed  = 1'b1;
                comb_code = semi_b_code(r_pend_kana);
            end else begin
                consumed  = 1'b0;
            end
        end
    end

    always_comb begin
        rec          = '0;
        rec.b_kind   = B_NONE;
        n_pend_valid = r_pend_valid;
        n_pend_kana  = r_pend_kana;
        n_closed     = r_closed;
        if (r_closed) begin
            // drop everything until the end flag reopens the string
            n_closed = !i_end_of_input;
        end else begin
            rec.a_v      = r_pend_valid;
            rec.a_code   = consumed ? comb_code : kana_code(r_pend_kana);
            n_pend_valid = 1'b0;
            n_pend_kana  = 8'h00;
            if (!consumed) begin
                if (i_in_byte == 8'h00) begin
                    rec.z_v  = 1'b1;
                    n_closed = !i_end_of_input;
                end else if (i_in_byte >= ASCII_LO && i_in_byte <= ASCII_HI) begin
                    rec.b_kind = B_BYTE;
                    rec.b_val  = {16'h0000, i_in_byte};
                end else if (i_in_byte >= KANA_FIRST && i_in_byte <= KANA_LAST) begin
                    if (new_a || new_b) begin
                        n_pend_valid = 1'b1;
                        n_pend_kana  = i_in_byte;
                    end else begin
                        rec.b_kind = B_CODE;
                        rec.b_val  = kana_code(i_in_byte);
                    end
                end
            end
            if (i_end_of_input && !(i_in_byte == 8'h00 && !consumed)) begin
                // flush a kana held by this very byte, then emit the closing zero
                if (n_pend_valid) begin
                    rec.b_kind = B_CODE;
                    rec.b_val  = kana_code(n_pend_kana);
                end
                n_pend_valid = 1'b0;
                n_pend_kana  = 8'h00;
                rec.z_v      = 1'b1;
                n_closed     = 1'b0;
            end
        end
    end

    assign o_rec = rec;
    assign o_wr  = accept && (rec.a_v || rec.z_v || rec.b_kind != B_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_kana  <= 8'h00;
            r_closed     <= 1'b0;
        end else if (accept) begin
            r_pend_valid <= n_pend_valid;
            r_pend_kana  <= n_pend_kana;
            r_closed     <= n_closed;
        end
    end

    `HWK_ASSERT_NOW(a_closed_no_pend, i_clk, i_rst_n, r_closed, !r_pend_valid, "pending kana while closed")
    `HWK_ASSERT_NOW(a_pend_voiceable, i_clk, i_rst_n, r_pend_valid, pend_a || pend_b, "pending kana cannot take a mark")
    `HWK_ASSERT_NOW(a_wr_not_full, i_clk, i_rst_n, o_wr, !i_q_full, "record written into a full queue")

endmodule

>>> hw/rtl/hwk_fifo.sv
// ----------------------------------------------------------------------------
// hwk_fifo
// Short show-ahead queue of records between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "halfwidth_katakana_to_utf8_defines.svh"

module hwk_fifo #(
    parameter int DEPTH = hwk_pkg::HWK_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  hwk_pkg::t_rec  i_rec,
    input  logic           i_rd,
    output hwk_pkg::t_rec  o_rec,
    output logic           o_full,
    output logic           o_empty
);
    import hwk_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (i_rd && !i_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `HWK_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_wr, !o_full, "write to full queue")
    `HWK_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_rd, !o_empty, "read from empty queue")
    `HWK_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "queue count out of range")

endmodule

>>> hw/rtl/hwk_back.sv
// ----------------------------------------------------------------------------
// hwk_back
// Drains records from the queue one UTF-8 byte per beat into the output
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "halfwidth_katakana_to_utf8_defines.svh"

module hwk_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hwk_pkg::t_rec  i_rec,
    input  logic           i_q_empty,
    output logic           o_q_rd,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_out_byte,
    output logic           o_last_of_run,
    output logic           o_end_of_text
);
    import hwk_pkg::*;

    localparam int NPOS = 7;

    logic            r_loaded;
    logic [NPOS-1:0] r_rem;
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic            r_out_last;
    logic            r_out_eot;

    logic [NPOS-1:0] rec_mask, cur_mask, iso, rem_next;
    logic [7:0]      pos_byte [NPOS];
    logic [7:0]      sel_byte;
    logic            have, can_load, load, last;

    // positions: three bytes of the first code, up to three of the second
    // slot, then the closing zero
    assign rec_mask = {i_rec.z_v,
                       i_rec.b_kind == B_CODE, i_rec.b_kind == B_CODE,
                       i_rec.b_kind != B_NONE,
                       i_rec.a_v, i_rec.a_v, i_rec.a_v};

    assign pos_byte[0] = i_rec.a_code[23:16];
    assign pos_byte[1] = i_rec.a_code[15:8];
    assign pos_byte[2] = i_rec.a_code[7:0];
    assign pos_byte[3] = (i_rec.b_kind == B_BYTE) ? i_rec.b_val[7:0] : i_rec.b_val[23:16];
    assign pos_byte[4] = i_rec.b_val[15:8];
    assign pos_byte[5] = i_rec.b_val[7:0];
    assign pos_byte[6] = 8'h00;

    assign cur_mask = r_loaded ? r_rem : rec_mask;
    assign have     = r_loaded || !i_q_empty;
    assign can_load = !r_out_valid || i_pop;
    assign load     = have && can_load;
    assign iso      = cur_mask & (~cur_mask + 1'b1);
    assign rem_next = cur_mask & ~iso;
    assign last     = (rem_next == '0);
    assign o_q_rd   = load && last;

    always_comb begin
        sel_byte = 8'h00;
        for (int i = 0; i < NPOS; i++) begin
            if (iso[i]) begin
                sel_byte = pos_byte[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_loaded <= !last;
            end
            if (can_load) begin
                r_out_valid <= have;
            end
        end
    end

    // payload: advance on every loaded beat
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rem      <= rem_next;
            r_out_byte <= sel_byte;
            r_out_last <= last;
            r_out_eot  <= iso[NPOS-1];
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_end_of_text = r_out_eot;

    `HWK_ASSERT_NOW(a_loaded_has_bytes, i_clk, i_rst_n, r_loaded, r_rem != '0, "record held with no bytes left")
    `HWK_ASSERT_NOW(a_loaded_head, i_clk, i_rst_n, r_loaded, !i_q_empty, "record held but queue empty")
    `HWK_ASSERT_NOW(a_eot_last, i_clk, i_rst_n, r_out_valid && r_out_eot, r_out_last && r_out_byte == 8'h00, "closing byte not last or not zero")
    `HWK_ASSERT_NEXT(a_rd_clears, i_clk, i_rst_n, o_q_rd, !r_loaded, "record still held after its last beat")

endmodule

>>> hw/rtl/halfwidth_katakana_to_utf8.sv
// ----------------------------------------------------------------------------
// halfwidth_katakana_to_utf8
// Single-byte text to UTF-8: bytes 20h to 7Fh pass, half-width katakana become
// three-byte full-width characters, marks fold into the preceding kana.
//
//   channel   handshake          payload
//   -------   ----------------   --------------------------------------------
//   input     push / full        i_in_byte, i_end_of_input
//   result    empty / pop        o_out_byte, o_last_of_run, o_end_of_text
//
// The front takes one byte per cycle while the record queue has room.
// The back emits one result byte per cycle while the output is popped; a byte
// gives anything from 0 to 7 results, and a kana gives three.
// The QUEUE_DEPTH record queue and the output register decouple the sides.
// Reset clears pending kana, closed-string flag, queue pointers and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module halfwidth_katakana_to_utf8 #(
    parameter int QUEUE_DEPTH = hwk_pkg::HWK_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_end_of_text
);
    import hwk_pkg::*;

    t_rec wr_rec, rd_rec;
    logic q_wr, q_rd, q_full, q_empty;

    hwk_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_q_full       (q_full),
        .o_full         (full),
        .o_wr           (q_wr),
        .o_rec          (wr_rec)
    );

    hwk_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_rec   (wr_rec),
        .i_rd    (q_rd),
        .o_rec   (rd_rec),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    hwk_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec         (rd_rec),
        .i_q_empty     (q_empty),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_end_of_text (o_end_of_text)
    );

endmodule
